FILE: rtl/core/asl_pkg.sv
// Shared types and constants for the actuator safety slew limiter.
package asl_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int NUM_WHEELS_DEF   = 4;
    localparam int OUT_SLOTS        = 8;

    localparam logic [7:0]  AGE_MAX = 8'd255;

    localparam logic [24:0] WHEEL_STEP_RST = 25'd83886;
    localparam logic [24:0] LEG_STEP_RST   = 25'd1678;
    localparam logic [7:0]  TIMEOUT_RST    = 8'd5;
    localparam logic [14:0] DEADBAND_RST   = 15'd41;
    localparam logic [14:0] TILT_RST       = 15'd11469;

    typedef enum logic [2:0] {
        OP_ACTION   = 3'd0,
        OP_ATTITUDE = 3'd1,
        OP_VELOCITY = 3'd2,
        OP_BUTTON   = 3'd3,
        OP_TICK     = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_NORMAL   = 3'd0,
        ST_DRY_RUN  = 3'd1,
        ST_ESTOP    = 3'd2,
        ST_WATCHDOG = 3'd3,
        ST_TILT     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        REG_WHEEL_STEP = 3'd0,
        REG_LEG_STEP   = 3'd1,
        REG_TIMEOUT    = 3'd2,
        REG_DEADBAND   = 3'd3,
        REG_TILT       = 3'd4,
        REG_DRY_RUN    = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TILT_MUL,
        S_TILT_CMP,
        S_TICK_CHECK,
        S_SLEW,
        S_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic tilt_mul;
        logic tilt_cmp;
        logic tick_check;
        logic slew;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       fault;
        logic       last_lane;
    } ctl_sts_t;

    typedef struct packed {
        logic [24:0] wheel_step;
        logic [24:0] leg_step;
        logic [7:0]  timeout_ticks;
        logic [14:0] deadband;
        logic [14:0] tilt_threshold;
        logic        dry_run;
    } cfg_t;

endpackage

FILE: rtl/core/asl_ctrl.sv
// Sequencer for one input word: capture, tilt math, tick checks, slew sweep, output.
module asl_ctrl
    import asl_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     out_busy,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_TILT_MUL;
                end
            end
            S_TILT_MUL: begin
                if (sts.op == OP_ATTITUDE) begin
                    cmd.tilt_mul = 1'b1;
                    state_next   = S_TILT_CMP;
                end else if (sts.op == OP_TICK) begin
                    state_next = S_TICK_CHECK;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_TILT_CMP: begin
                cmd.tilt_cmp = 1'b1;
                state_next   = S_IDLE;
            end
            S_TICK_CHECK: begin
                cmd.tick_check = 1'b1;
                state_next     = sts.fault ? S_OUT : S_SLEW;
            end
            S_SLEW: begin
                cmd.slew = 1'b1;
                if (sts.last_lane) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/asl_dp.sv
// Datapath: action registers, ages, tilt products, slew lane and result register.
module asl_dp
    import asl_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int NUM_WHEELS   = NUM_WHEELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  ctl_cmd_t           cmd,
    output ctl_sts_t           sts,
    output logic               out_busy,
    input  logic [2:0]         s_operation,
    input  logic [2:0]         s_channel,
    input  logic signed [31:0] s_action_value,
    input  logic signed [15:0] s_quat_w,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    input  logic signed [15:0] s_linear_x,
    input  logic signed [15:0] s_angular_z,
    input  logic               s_stop_button,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_ch   [OUT_SLOTS],
    output logic [2:0]         m_status
);

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic signed [31:0] staged_reg [NUM_CHANNELS];
    logic signed [31:0] target_reg [NUM_CHANNELS];
    logic signed [31:0] safe_reg   [NUM_CHANNELS];
    logic               estop_reg, tilt_reg, czero_reg;
    logic [7:0]         act_age_reg, att_age_reg;
    logic [2:0]         op_reg;
    logic [2:0]         fstat_reg;
    logic [CW-1:0]      lane_reg;
    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [31:0] pw_reg, px_reg, py_reg, pz_reg;
    logic               m_valid_reg;
    logic [31:0]        m_ch_reg [OUT_SLOTS];
    logic [2:0]         m_status_reg;

    logic [7:0]         act_age_inc, att_age_inc;
    logic               tick_fault;
    logic signed [33:0] up_sum;
    logic [33:0]        norm_sum;
    logic signed [49:0] up_scaled;
    logic signed [50:0] thr_prod;
    logic [15:0]        lx_mag, az_mag;
    logic signed [32:0] cur_ext, tgt_ext, delta, step_ext, slew_val;
    logic signed [31:0] tgt_eff;
    logic [24:0]        lane_step;
    logic               lane_wheel;

    assign act_age_inc = (act_age_reg == AGE_MAX) ? act_age_reg : act_age_reg + 8'd1;
    assign att_age_inc = (att_age_reg == AGE_MAX) ? att_age_reg : att_age_reg + 8'd1;
    assign tick_fault  = estop_reg || (act_age_inc > cfg.timeout_ticks)
                      || (att_age_inc > cfg.timeout_ticks) || tilt_reg;

    assign up_sum    = 34'(pw_reg) + 34'(pz_reg) - 34'(px_reg) - 34'(py_reg);
    assign norm_sum  = 34'(unsigned'(pw_reg)) + 34'(unsigned'(px_reg))
                     + 34'(unsigned'(py_reg)) + 34'(unsigned'(pz_reg));
    assign up_scaled = 50'(up_sum) <<< 14;
    assign thr_prod  = signed'({1'b0, 50'(norm_sum) * 50'(cfg.tilt_threshold)});

    assign lx_mag = s_linear_x[15]  ? 16'(-s_linear_x)  : 16'(s_linear_x);
    assign az_mag = s_angular_z[15] ? 16'(-s_angular_z) : 16'(s_angular_z);

    assign lane_wheel = (32'(lane_reg) < 32'(NUM_WHEELS));
    assign tgt_eff    = (lane_wheel && czero_reg) ? 32'sd0 : target_reg[lane_reg];
    assign lane_step  = lane_wheel ? cfg.wheel_step : cfg.leg_step;
    assign cur_ext    = 33'(safe_reg[lane_reg]);
    assign tgt_ext    = 33'(tgt_eff);
    assign step_ext   = signed'({8'd0, lane_step});
    assign delta      = tgt_ext - cur_ext;

    always_comb begin
        if (delta > step_ext) begin
            slew_val = cur_ext + step_ext;
        end else if (delta < -step_ext) begin
            slew_val = cur_ext - step_ext;
        end else begin
            slew_val = tgt_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                staged_reg[i] <= '0;
                target_reg[i] <= '0;
                safe_reg[i]   <= '0;
            end
            estop_reg   <= 1'b0;
            tilt_reg    <= 1'b0;
            czero_reg   <= 1'b1;
            act_age_reg <= '0;
            att_age_reg <= '0;
            op_reg      <= '0;
            fstat_reg   <= ST_NORMAL;
            lane_reg    <= '0;
        end else begin
            if (cmd.capture) begin
                op_reg   <= s_operation;
                lane_reg <= '0;
                qw_reg   <= s_quat_w;
                qx_reg   <= s_quat_x;
                qy_reg   <= s_quat_y;
                qz_reg   <= s_quat_z;
                case (s_operation)
                    OP_ACTION: begin
                        if (32'(s_channel) < 32'(NUM_CHANNELS)) begin
                            staged_reg[s_channel[CW-1:0]] <= s_action_value;
                            if (32'(s_channel) == 32'(NUM_CHANNELS - 1)) begin
                                for (int i = 0; i < NUM_CHANNELS - 1; i++) begin
                                    target_reg[i] <= staged_reg[i];
                                end
                                target_reg[NUM_CHANNELS-1] <= s_action_value;
                                act_age_reg <= '0;
                            end
                        end
                    end
                    OP_ATTITUDE: begin
                        att_age_reg <= '0;
                    end
                    OP_VELOCITY: begin
                        czero_reg <= (lx_mag < 16'(cfg.deadband))
                                  && (az_mag < 16'(cfg.deadband));
                    end
                    OP_BUTTON: begin
                        if (s_stop_button) begin
                            estop_reg <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.tilt_mul) begin
                pw_reg <= qw_reg * qw_reg;
                px_reg <= qx_reg * qx_reg;
                py_reg <= qy_reg * qy_reg;
                pz_reg <= qz_reg * qz_reg;
            end
            if (cmd.tilt_cmp) begin
                tilt_reg <= 51'(up_scaled) < thr_prod;
            end
            if (cmd.tick_check) begin
                act_age_reg <= act_age_inc;
                att_age_reg <= att_age_inc;
                if (estop_reg) begin
                    fstat_reg <= ST_ESTOP;
                end else if (act_age_inc > cfg.timeout_ticks
                          || att_age_inc > cfg.timeout_ticks) begin
                    fstat_reg <= ST_WATCHDOG;
                end else if (tilt_reg) begin
                    fstat_reg <= ST_TILT;
                end else begin
                    fstat_reg <= cfg.dry_run ? ST_DRY_RUN : ST_NORMAL;
                end
            end
            if (cmd.slew) begin
                safe_reg[lane_reg]   <= 32'(slew_val);
                target_reg[lane_reg] <= tgt_eff;
                lane_reg             <= lane_reg + CW'(1);
            end
        end
    end

    assign sts.op        = op_reg;
    assign sts.fault     = tick_fault;
    assign sts.last_lane = (32'(lane_reg) == 32'(NUM_CHANNELS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status_reg <= fstat_reg;
            for (int j = 0; j < OUT_SLOTS; j++) begin
                if (j < NUM_CHANNELS && fstat_reg == ST_NORMAL) begin
                    m_ch_reg[j] <= safe_reg[j];
                end else begin
                    m_ch_reg[j] <= '0;
                end
            end
        end
    end

    assign out_busy = m_valid_reg && !m_ready;
    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_ch     = m_ch_reg;

endmodule

FILE: rtl/core/asl_regs.sv
// APB register file for step sizes, timeout, deadband, tilt threshold and dry run.
module asl_regs
    import asl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic [2:0] idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wheel_step     <= WHEEL_STEP_RST;
            cfg_reg.leg_step       <= LEG_STEP_RST;
            cfg_reg.timeout_ticks  <= TIMEOUT_RST;
            cfg_reg.deadband       <= DEADBAND_RST;
            cfg_reg.tilt_threshold <= TILT_RST;
            cfg_reg.dry_run        <= 1'b1;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_WHEEL_STEP: cfg_reg.wheel_step     <= pwdata[24:0];
                REG_LEG_STEP:   cfg_reg.leg_step       <= pwdata[24:0];
                REG_TIMEOUT:    cfg_reg.timeout_ticks  <= pwdata[7:0];
                REG_DEADBAND:   cfg_reg.deadband       <= pwdata[14:0];
                REG_TILT:       cfg_reg.tilt_threshold <= pwdata[14:0];
                REG_DRY_RUN:    cfg_reg.dry_run        <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_WHEEL_STEP: prdata = 32'(cfg_reg.wheel_step);
            REG_LEG_STEP:   prdata = 32'(cfg_reg.leg_step);
            REG_TIMEOUT:    prdata = 32'(cfg_reg.timeout_ticks);
            REG_DEADBAND:   prdata = 32'(cfg_reg.deadband);
            REG_TILT:       prdata = 32'(cfg_reg.tilt_threshold);
            REG_DRY_RUN:    prdata = 32'(cfg_reg.dry_run);
            default:        prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/actuator_safety_slew_limiter_top.sv
// Top level of the actuator safety slew limiter.
// Action, velocity and button words are captured; attitude words add tilt math.
// A tick runs a tick check, then the single slew lane, which updates one
// channel per cycle, and then loads the output; a faulted tick skips the lane.
// One word at a time; a finished result waits in the output register.
// Synchronous active-low reset restores config defaults and idles the sequencer.
module actuator_safety_slew_limiter_top
    import asl_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int NUM_WHEELS   = NUM_WHEELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_operation,
    input  logic [2:0]         s_channel,
    input  logic signed [31:0] s_action_value,
    input  logic signed [15:0] s_quat_w,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    input  logic signed [15:0] s_linear_x,
    input  logic signed [15:0] s_angular_z,
    input  logic               s_stop_button,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_ch0,
    output logic signed [31:0] m_out_ch1,
    output logic signed [31:0] m_out_ch2,
    output logic signed [31:0] m_out_ch3,
    output logic signed [31:0] m_out_ch4,
    output logic signed [31:0] m_out_ch5,
    output logic signed [31:0] m_out_ch6,
    output logic signed [31:0] m_out_ch7,
    output logic [2:0]         m_status
);

    cfg_t        cfg;
    ctl_cmd_t    cmd;
    ctl_sts_t    sts;
    logic        out_busy;
    logic [31:0] m_ch [OUT_SLOTS];

    asl_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    asl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_busy (out_busy),
        .sts      (sts),
        .cmd      (cmd)
    );

    asl_dp #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_WHEELS   (NUM_WHEELS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd            (cmd),
        .sts            (sts),
        .out_busy       (out_busy),
        .s_operation    (s_operation),
        .s_channel      (s_channel),
        .s_action_value (s_action_value),
        .s_quat_w       (s_quat_w),
        .s_quat_x       (s_quat_x),
        .s_quat_y       (s_quat_y),
        .s_quat_z       (s_quat_z),
        .s_linear_x     (s_linear_x),
        .s_angular_z    (s_angular_z),
        .s_stop_button  (s_stop_button),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ch           (m_ch),
        .m_status       (m_status)
    );

    assign m_out_ch0 = m_ch[0];
    assign m_out_ch1 = m_ch[1];
    assign m_out_ch2 = m_ch[2];
    assign m_out_ch3 = m_ch[3];
    assign m_out_ch4 = m_ch[4];
    assign m_out_ch5 = m_ch[5];
    assign m_out_ch6 = m_ch[6];
    assign m_out_ch7 = m_ch[7];

endmodule
